/* hw/rtl/gql_pkg.sv */
// Shared types, constants and helpers for the glyph quad layout block.
package gql_pkg;

    // Character range held in the glyph table
    localparam int FIRST_CODE   = 32;
    localparam int END_CODE     = 128;
    localparam int CODE_W       = 7;
    localparam int NEWLINE_CODE = 10;
    localparam int GLYPH_DEPTH  = END_CODE - FIRST_CODE;
    localparam int GLYPH_AW     = $clog2(GLYPH_DEPTH);

    // Vertices per drawn glyph
    localparam int VERTS  = 6;
    localparam int VERT_W = $clog2(VERTS);
    localparam logic [VERT_W-1:0] LAST_VERT = VERT_W'(VERTS - 1);

    // Stream payload widths
    localparam int IN_DATA_W     = 112;
    localparam int OUT_FIELDS_W  = 98;
    localparam int OUT_DATA_W    = 104;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_POINT_SIZE,
        REG_ATLAS_W,
        REG_ATLAS_H
    } t_reg_idx;

    // Register widths and reset values
    localparam int COORD_W = 32;
    localparam int SCALE_W = 25;
    localparam int POINT_W = 10;
    localparam int ATLAS_W = 16;
    localparam logic signed [COORD_W-1:0] ORIGIN_X_RST = 32'shFF00_0000;
    localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST = 32'sh0100_0000;
    localparam logic [SCALE_W-1:0]        SCALE_RST    = 25'd16384;
    localparam logic [POINT_W-1:0]        POINT_RST    = 10'd16;
    localparam logic [ATLAS_W-1:0]        ATLAS_RST    = 16'd1;

    // Texture coordinate format, Q1.16 capped at 1.0
    localparam int TEX_W = 17;
    localparam logic [TEX_W-1:0] TEX_ONE = 17'h1_0000;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Arithmetic widths: 17x26 signed multiply, 44 bit sums before clamping
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = PROD_W + 1;

    // One glyph table entry
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bl;
        logic signed [15:0] bt;
        logic [11:0]        bw;
        logic [11:0]        bh;
        logic [15:0]        tx;
    } t_glyph;

    localparam int GLYPH_W = $bits(t_glyph);

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NEWLINE,
        S_MUL_OFS,
        S_MUL_BOX,
        S_MUL_ADV,
        S_ADVANCE,
        S_DIV_GO,
        S_DIV_RUN,
        S_EMIT
    } t_state;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DECODE,
        OP_NEWLINE,
        OP_MUL_OFS,
        OP_MUL_BOX,
        OP_MUL_ADV,
        OP_ADVANCE,
        OP_DIV_START,
        OP_DIV_STORE,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [1:0] {
        TEX_U0,
        TEX_U1,
        TEX_V1
    } t_tex_sel;

    typedef struct packed {
        t_dp_op              op;
        t_tex_sel            sel;
        logic [VERT_W-1:0]   vert;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic code_ok;
        logic is_newline;
        logic empty;
        logic div_busy;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic right;
        logic bottom;
    } t_corner;

    // Clamp a wide signed sum to the 32 bit signed range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32'sh7FFF_FFFF);
        lo = ~hi;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    // Quad corner of each vertex: two triangles
    function automatic t_corner vert_corner(input logic [VERT_W-1:0] k);
        t_corner c;
        c = '0;
        case (k)
            3'd0: c = '{right: 1'b0, bottom: 1'b0};
            3'd1: c = '{right: 1'b1, bottom: 1'b0};
            3'd2: c = '{right: 1'b0, bottom: 1'b1};
            3'd3: c = '{right: 1'b1, bottom: 1'b0};
            3'd4: c = '{right: 1'b0, bottom: 1'b1};
            3'd5: c = '{right: 1'b1, bottom: 1'b1};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/gql_ram.sv */
// Generic single write port RAM with registered read.
module gql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gql_div.sv */
// Bit-serial divider for texture coordinates: floor(t * 65536 / d), capped at 1.0.
module gql_div
    import gql_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TEX_W-1:0]   i_dividend,
    input  logic [ATLAS_W-1:0] i_divisor,
    output logic               o_busy,
    output logic [TEX_W-1:0]   o_quot
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ATLAS_W-1:0]   r_rem;
    logic [ATLAS_W-1:0]   r_div;
    logic [TEX_W-1:0]     r_quot;
    logic [ATLAS_W:0]     w_rem2;
    logic                 w_fit;
    logic                 w_full;

    // t >= d means the quotient reaches 1.0 and is capped
    assign w_full = i_dividend >= {1'b0, i_divisor};
    assign w_rem2 = {r_rem, 1'b0};
    assign w_fit  = w_rem2 >= {1'b0, r_div};

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= w_full ? '0 : DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= i_dividend[ATLAS_W-1:0];
            r_quot <= w_full ? TEX_ONE : '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_fit ? ATLAS_W'(w_rem2 - {1'b0, r_div}) : w_rem2[ATLAS_W-1:0];
            r_quot <= {r_quot[TEX_W-2:0], w_fit};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/gql_datapath.sv */
// Datapath: glyph table, pen, multipliers, divider and output register.
module gql_datapath
    import gql_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    // Configuration registers
    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic [SCALE_W-1:0]        r_scale_x;
    logic [SCALE_W-1:0]        r_scale_y;
    logic [POINT_W-1:0]        r_point_size;
    logic [ATLAS_W-1:0]        r_atlas_w;
    logic [ATLAS_W-1:0]        r_atlas_h;

    // Request fields
    logic [CODE_W-1:0]   w_code;
    logic [GLYPH_AW-1:0] w_idx;
    logic                w_code_ok;
    t_glyph              w_in_glyph;
    logic                r_is_load;
    logic                r_start;
    logic                r_is_nl;
    logic                r_code_ok;
    logic [GLYPH_AW-1:0] r_idx;
    t_glyph              r_load_data;

    // Glyph table
    logic [GLYPH_DEPTH-1:0] r_valid;
    logic                   w_we;
    logic [GLYPH_W-1:0]     w_rdata;
    t_glyph                 r_glyph;

    // Pen and arithmetic
    logic signed [COORD_W-1:0] r_pen_x;
    logic signed [COORD_W-1:0] r_pen_y;
    logic signed [MUL_A_W-1:0] w_mul_ax;
    logic signed [MUL_A_W-1:0] w_mul_ay;
    logic signed [MUL_B_W-1:0] w_mul_bx;
    logic signed [MUL_B_W-1:0] w_mul_by;
    logic signed [PROD_W-1:0]  w_prod_x;
    logic signed [PROD_W-1:0]  w_prod_y;
    logic signed [PROD_W-1:0]  r_mx;
    logic signed [PROD_W-1:0]  r_my;
    logic signed [WIDE_W-1:0]  r_x2;
    logic signed [WIDE_W-1:0]  r_y2;
    logic signed [WIDE_W-1:0]  r_x2w;
    logic signed [WIDE_W-1:0]  r_y2h;
    logic                      r_empty;
    logic signed [COORD_W-1:0] r_vx0;
    logic signed [COORD_W-1:0] r_vx1;
    logic signed [COORD_W-1:0] r_vy0;
    logic signed [COORD_W-1:0] r_vy1;

    // Texture coordinates
    logic [TEX_W-1:0]   w_div_t;
    logic [ATLAS_W-1:0] w_div_d;
    logic               w_div_busy;
    logic [TEX_W-1:0]   w_div_q;
    logic [TEX_W-1:0]   r_u0;
    logic [TEX_W-1:0]   r_u1;
    logic [TEX_W-1:0]   r_v1;

    // Output register
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic [TEX_W-1:0]          r_out_u;
    logic [TEX_W-1:0]          r_out_v;
    logic                      r_out_last;
    logic                      w_out_free;
    t_corner                   w_corner;

    // Unpack the request
    assign w_code    = i_s_tdata[6:0];
    assign w_idx     = GLYPH_AW'(int'(w_code) - FIRST_CODE);
    assign w_code_ok = (int'(w_code) >= FIRST_CODE) && (int'(w_code) < END_CODE);

    always_comb begin
        w_in_glyph    = '0;
        w_in_glyph.ax = i_s_tdata[23:8];
        w_in_glyph.ay = i_s_tdata[39:24];
        w_in_glyph.bw = i_s_tdata[51:40];
        w_in_glyph.bh = i_s_tdata[63:52];
        w_in_glyph.bl = i_s_tdata[79:64];
        w_in_glyph.bt = i_s_tdata[95:80];
        w_in_glyph.tx = i_s_tdata[111:96];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= ORIGIN_X_RST;
            r_origin_y   <= ORIGIN_Y_RST;
            r_scale_x    <= SCALE_RST;
            r_scale_y    <= SCALE_RST;
            r_point_size <= POINT_RST;
            r_atlas_w    <= ATLAS_RST;
            r_atlas_h    <= ATLAS_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_ORIGIN_X:   r_origin_x   <= i_cfg_wdata;
                REG_ORIGIN_Y:   r_origin_y   <= i_cfg_wdata;
                REG_SCALE_X:    r_scale_x    <= i_cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:    r_scale_y    <= i_cfg_wdata[SCALE_W-1:0];
                REG_POINT_SIZE: r_point_size <= i_cfg_wdata[POINT_W-1:0];
                REG_ATLAS_W:    r_atlas_w    <= i_cfg_wdata[ATLAS_W-1:0];
                REG_ATLAS_H:    r_atlas_h    <= i_cfg_wdata[ATLAS_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT) begin
            r_is_load   <= i_s_tuser;
            r_start     <= i_s_tdata[7];
            r_is_nl     <= w_code == CODE_W'(NEWLINE_CODE);
            r_code_ok   <= w_code_ok;
            r_idx       <= w_idx;
            r_load_data <= w_in_glyph;
        end
    end

    // Glyph table: entries never loaded read as zero
    assign w_we = (i_cmd.op == OP_DECODE) && r_is_load && r_code_ok;

    gql_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (r_load_data),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DECODE) begin
            r_glyph <= r_valid[r_idx] ? t_glyph'(w_rdata) : '0;
        end
    end

    // Multiplier operands per step
    always_comb begin
        w_mul_ax = '0;
        w_mul_ay = MUL_A_W'(r_point_size);
        unique case (i_cmd.op)
            OP_MUL_OFS: begin
                w_mul_ax = MUL_A_W'(r_glyph.bl);
                w_mul_ay = MUL_A_W'(r_glyph.bt);
            end
            OP_MUL_BOX: begin
                w_mul_ax = MUL_A_W'(r_glyph.bw);
                w_mul_ay = MUL_A_W'(r_glyph.bh);
            end
            OP_MUL_ADV: begin
                w_mul_ax = MUL_A_W'(r_glyph.ax);
                w_mul_ay = MUL_A_W'(r_glyph.ay);
            end
            default: ;
        endcase
    end

    assign w_mul_bx = MUL_B_W'(r_scale_x);
    assign w_mul_by = MUL_B_W'(r_scale_y);
    assign w_prod_x = w_mul_ax * w_mul_bx;
    assign w_prod_y = w_mul_ay * w_mul_by;

    // Pen state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_DECODE: begin
                    if (!r_is_load && r_start) begin
                        r_pen_x <= r_origin_x;
                        r_pen_y <= r_origin_y;
                    end
                end
                OP_NEWLINE: begin
                    r_pen_x <= r_origin_x;
                    r_pen_y <= sat32(WIDE_W'(r_pen_y) - WIDE_W'(r_my));
                end
                OP_ADVANCE: begin
                    r_pen_x <= sat32(WIDE_W'(r_pen_x) + WIDE_W'(r_mx));
                    r_pen_y <= sat32(WIDE_W'(r_pen_y) + WIDE_W'(r_my));
                end
                default: ;
            endcase
        end
    end

    // Quad geometry: offsets, box, advance, then clamping
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_DECODE: begin
                r_my <= w_prod_y;
            end
            OP_MUL_OFS: begin
                r_mx <= w_prod_x;
                r_my <= w_prod_y;
            end
            OP_MUL_BOX: begin
                r_x2 <= WIDE_W'(r_pen_x) + WIDE_W'(r_mx);
                r_y2 <= WIDE_W'(r_pen_y) + WIDE_W'(r_my);
                r_mx <= w_prod_x;
                r_my <= w_prod_y;
            end
            OP_MUL_ADV: begin
                r_x2w   <= r_x2 + WIDE_W'(r_mx);
                r_y2h   <= r_y2 - WIDE_W'(r_my);
                r_empty <= (r_mx == '0) || (r_my == '0);
                r_mx    <= w_prod_x;
                r_my    <= w_prod_y;
            end
            OP_ADVANCE: begin
                r_vx0 <= sat32(r_x2);
                r_vx1 <= sat32(r_x2w);
                r_vy0 <= sat32(r_y2);
                r_vy1 <= sat32(r_y2h);
            end
            default: ;
        endcase
    end

    // Divider operands; zero atlas size counts as one
    always_comb begin
        w_div_t = TEX_W'(r_glyph.tx);
        w_div_d = (r_atlas_w == '0) ? ATLAS_W'(1) : r_atlas_w;
        unique case (i_cmd.sel)
            TEX_U0: ;
            TEX_U1: w_div_t = TEX_W'(r_glyph.tx) + TEX_W'(r_glyph.bw);
            TEX_V1: begin
                w_div_t = TEX_W'(r_glyph.bh);
                w_div_d = (r_atlas_h == '0) ? ATLAS_W'(1) : r_atlas_h;
            end
            default: ;
        endcase
    end

    gql_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_START),
        .i_dividend (w_div_t),
        .i_divisor  (w_div_d),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DIV_STORE) begin
            unique case (i_cmd.sel)
                TEX_U0:  r_u0 <= w_div_q;
                TEX_U1:  r_u1 <= w_div_q;
                TEX_V1:  r_v1 <= w_div_q;
                default: ;
            endcase
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_corner   = vert_corner(i_cmd.vert);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out_x    <= w_corner.right  ? r_vx1 : r_vx0;
            r_out_y    <= w_corner.bottom ? r_vy1 : r_vy0;
            r_out_u    <= w_corner.right  ? r_u1  : r_u0;
            r_out_v    <= w_corner.bottom ? r_v1  : '0;
            r_out_last <= i_cmd.vert == LAST_VERT;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_v, r_out_u, r_out_y, r_out_x};
    assign o_m_tlast  = r_out_last;

    // Status to the controller
    always_comb begin
        o_status            = '0;
        o_status.is_load    = r_is_load;
        o_status.code_ok    = r_code_ok;
        o_status.is_newline = r_is_nl;
        o_status.empty      = r_empty;
        o_status.div_busy   = w_div_busy;
        o_status.out_free   = w_out_free;
    end

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |-> (!r_out_valid || i_m_tready))
        else $error("vertex loaded over a pending vertex");

    a_load_marks_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DECODE && r_is_load && r_code_ok) |=> r_valid[$past(r_idx)])
        else $error("loaded glyph entry not marked valid");

endmodule

/* hw/rtl/gql_ctrl.sv */
// Controller: sequences decode, pen math, divisions and vertex output.
module gql_ctrl
    import gql_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state            r_state;
    t_state            n_state;
    t_tex_sel          r_sel;
    t_tex_sel          n_sel;
    logic [VERT_W-1:0] r_vert;
    logic [VERT_W-1:0] n_vert;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= TEX_U0;
            r_vert  <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_vert  <= n_vert;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_vert     = r_vert;
        o_s_tready = 1'b0;
        o_cmd      = '{op: OP_NONE, sel: r_sel, vert: r_vert};
        unique case (r_state)
            S_IDLE: begin
                // no request is taken while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = OP_DECODE;
                if (i_status.is_load) begin
                    n_state = S_IDLE;
                end else if (i_status.is_newline) begin
                    n_state = S_NEWLINE;
                end else if (!i_status.code_ok) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL_OFS;
                end
            end
            S_NEWLINE: begin
                o_cmd.op = OP_NEWLINE;
                n_state  = S_IDLE;
            end
            S_MUL_OFS: begin
                o_cmd.op = OP_MUL_OFS;
                n_state  = S_MUL_BOX;
            end
            S_MUL_BOX: begin
                o_cmd.op = OP_MUL_BOX;
                n_state  = S_MUL_ADV;
            end
            S_MUL_ADV: begin
                o_cmd.op = OP_MUL_ADV;
                n_state  = S_ADVANCE;
            end
            S_ADVANCE: begin
                o_cmd.op = OP_ADVANCE;
                n_sel    = TEX_U0;
                n_state  = i_status.empty ? S_IDLE : S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = OP_DIV_STORE;
                    unique case (r_sel)
                        TEX_U0: begin
                            n_sel   = TEX_U1;
                            n_state = S_DIV_GO;
                        end
                        TEX_U1: begin
                            n_sel   = TEX_V1;
                            n_state = S_DIV_GO;
                        end
                        default: begin
                            n_vert  = '0;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (r_vert == LAST_VERT) begin
                        n_vert  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_vert = r_vert + VERT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_last_vertex_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT && o_cmd.vert == LAST_VERT) |=> (r_state == S_IDLE))
        else $error("glyph did not finish after its sixth vertex");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DECODE && o_cmd.op == OP_DECODE))
        else $error("accepted request not decoded next cycle");

endmodule

/* hw/rtl/glyph_quad_layout.sv */
// Top level of the glyph quad layout block: controller plus datapath.
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tuser = cmd, tdata = draw/load request
//  m_axis    out  tvalid/tready          tdata = vertex, tlast = sixth vertex
//  i_cfg     in   i_cfg_we (no wait)     i_cfg_addr = register, i_cfg_wdata
//
//  One request at a time. Load and unprintable code end after decode; a
//  newline then moves the pen. A drawn glyph: table read and pen math,
//  then three texture divisions on one bit-serial divider (no serial
//  steps if capped at 1.0), then six vertices into the output register.
//  Glyphs of zero size finish after the pen math.
//  The last vertex may still wait in the output register when the next
//  request is taken; output stalls hold the controller in vertex output.
//  Synchronous active-low reset; the glyph table reads as zero until loaded,
//  with no clearing pass.
module glyph_quad_layout
    import gql_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [6:0] char_code, [7] start_text, [23:8] advance_x, [39:24] advance_y,
    // [51:40] box_width, [63:52] box_height, [79:64] bearing_left,
    // [95:80] bearing_top, [111:96] atlas_x
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] vert_x, [63:32] vert_y, [80:64] tex_u, [97:81] tex_v, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    gql_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gql_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

/* dv/tb_glyph_quad_layout.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench for glyph_quad_layout with its own layout predictor.
module tb_glyph_quad_layout
    import gql_pkg::*;
();

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int QUIET_CYCLES = 100;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int WARMUP_LOADS = 16;

    // Request payload, lowest field last so it packs straight onto tdata
    typedef struct packed {
        logic [15:0]        atlas_x;
        logic signed [15:0] bearing_top;
        logic signed [15:0] bearing_left;
        logic [11:0]        box_h;
        logic [11:0]        box_w;
        logic signed [15:0] adv_y;
        logic signed [15:0] adv_x;
        logic               start;
        logic [CODE_W-1:0]  code;
    } t_glyph_req;

    typedef struct packed {
        logic       cmd;
        t_glyph_req req;
    } t_layout_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TEX_W-1:0]          u;
        logic [TEX_W-1:0]          v;
        logic                      last;
    } t_vertex;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Predictor state: glyph table, pen and register copies
    t_glyph_req                glyph_tab [GLYPH_DEPTH] = '{default: '0};
    longint                    pen_x = 0;
    longint                    pen_y = 0;
    logic signed [COORD_W-1:0] org_x = ORIGIN_X_RST;
    logic signed [COORD_W-1:0] org_y = ORIGIN_Y_RST;
    logic [SCALE_W-1:0]        scl_x = SCALE_RST;
    logic [SCALE_W-1:0]        scl_y = SCALE_RST;
    logic [POINT_W-1:0]        pt_size = POINT_RST;
    logic [ATLAS_W-1:0]        atlas_w = ATLAS_RST;
    logic [ATLAS_W-1:0]        atlas_h = ATLAS_RST;

    t_vertex      vtx_q[$];
    t_layout_item pending_q[$];
    t_layout_item offer_item = '0;
    bit           holding = 1'b0;
    t_idle_mode   idle_mode = IDLE_NONE;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           quiet_cnt = 0;
    int           err_cnt = 0;
    int           load_cnt = 0;
    int           draw_cnt = 0;
    int           vert_cnt = 0;
    int           phase_cnt = 0;

    glyph_quad_layout i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q1.16 texel fraction, floor, capped at 1.0; size zero counts as one
    function automatic logic [TEX_W-1:0] tex_frac(input longint texels, input longint size);
        longint q;
        q = (texels * 65536) / ((size == 0) ? 1 : size);
        return (q > longint'(TEX_ONE)) ? TEX_ONE : TEX_W'(q);
    endfunction

    function automatic bit code_in_table(input logic [CODE_W-1:0] code);
        return int'(code) >= FIRST_CODE && int'(code) < END_CODE;
    endfunction

    function automatic void push_vertex(input longint px, input longint py,
                                        input logic [TEX_W-1:0] tu,
                                        input logic [TEX_W-1:0] tv, input logic lst);
        vtx_q.push_back('{x: 32'(clamp32(px)), y: 32'(clamp32(py)), u: tu, v: tv, last: lst});
    endfunction

    // Layout of one accepted request: table update, pen move, quad vertices
    function automatic void layout_predict(input t_layout_item it);
        t_glyph_req       g;
        longint           sx, sy, x2, y2, w, h;
        logic [TEX_W-1:0] u0, u1, v1;
        sx = longint'(scl_x);
        sy = longint'(scl_y);
        if (it.cmd == CMD_LOAD) begin
            if (code_in_table(it.req.code)) begin
                glyph_tab[int'(it.req.code) - FIRST_CODE] = it.req;
            end
            return;
        end
        if (it.req.start) begin
            pen_x = longint'(org_x);
            pen_y = longint'(org_y);
        end
        if (int'(it.req.code) == NEWLINE_CODE) begin
            pen_x = longint'(org_x);
            pen_y = clamp32(pen_y - longint'(pt_size) * sy);
            return;
        end
        if (!code_in_table(it.req.code)) begin
            return;
        end
        g  = glyph_tab[int'(it.req.code) - FIRST_CODE];
        x2 = pen_x + longint'($signed(g.bearing_left)) * sx;
        y2 = pen_y + longint'($signed(g.bearing_top)) * sy;
        w  = longint'(g.box_w) * sx;
        h  = longint'(g.box_h) * sy;
        pen_x = clamp32(pen_x + longint'($signed(g.adv_x)) * sx);
        pen_y = clamp32(pen_y + longint'($signed(g.adv_y)) * sy);
        // empty glyph: pen moves, nothing drawn
        if (w == 0 || h == 0) begin
            return;
        end
        u0 = tex_frac(longint'(g.atlas_x), longint'(atlas_w));
        u1 = tex_frac(longint'(g.atlas_x) + longint'(g.box_w), longint'(atlas_w));
        v1 = tex_frac(longint'(g.box_h), longint'(atlas_h));
        push_vertex(x2,     y2,     u0, '0, 1'b0);
        push_vertex(x2 + w, y2,     u1, '0, 1'b0);
        push_vertex(x2,     y2 - h, u0, v1, 1'b0);
        push_vertex(x2 + w, y2,     u1, '0, 1'b0);
        push_vertex(x2,     y2 - h, u0, v1, 1'b0);
        push_vertex(x2 + w, y2 - h, u1, v1, 1'b1);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Sampling at the rising edge: register writes, requests, vertices
    always @(posedge i_clk) begin : mon_proc
        t_layout_item seen;
        t_vertex      want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ORIGIN_X:   org_x = i_cfg_wdata;
                    REG_ORIGIN_Y:   org_y = i_cfg_wdata;
                    REG_SCALE_X:    scl_x = i_cfg_wdata[SCALE_W-1:0];
                    REG_SCALE_Y:    scl_y = i_cfg_wdata[SCALE_W-1:0];
                    REG_POINT_SIZE: pt_size = i_cfg_wdata[POINT_W-1:0];
                    REG_ATLAS_W:    atlas_w = i_cfg_wdata[ATLAS_W-1:0];
                    REG_ATLAS_H:    atlas_h = i_cfg_wdata[ATLAS_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.cmd = s_axis_tuser;
                seen.req = s_axis_tdata;
                layout_predict(seen);
                if (seen.cmd == CMD_LOAD) begin
                    load_cnt++;
                end else begin
                    draw_cnt++;
                end
                holding = 1'b0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                vert_cnt++;
                if (vtx_q.size() == 0) begin
                    $display("%0t: vertex with none expected, actual x %0d y %0d u %0d v %0d",
                             $time, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                             m_axis_tdata[80:64], m_axis_tdata[97:81]);
                    err_cnt++;
                end else begin
                    want = vtx_q.pop_front();
                    check_field("vert_x", $signed(want.x), $signed(m_axis_tdata[31:0]));
                    check_field("vert_y", $signed(want.y), $signed(m_axis_tdata[63:32]));
                    check_field("tex_u", want.u, m_axis_tdata[80:64]);
                    check_field("tex_v", want.v, m_axis_tdata[97:81]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cnt <= 0;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
        if (quiet_cnt == STALL_LIMIT) begin
            $display("%0t: nothing moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Request driver: holds a request until taken, gaps by idle mode
    always @(negedge i_clk) begin : drive_proc
        bit gap;
        gap = (idle_mode == IDLE_SEND && $urandom_range(99) < 51) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 27);
        if (!holding && pending_q.size() != 0 && !gap) begin
            offer_item = pending_q.pop_front();
            holding = 1'b1;
        end
        s_axis_tvalid <= holding;
        s_axis_tdata  <= offer_item.req;
        s_axis_tuser  <= offer_item.cmd;
    end

    // Vertex receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin : recv_proc
        bit stall;
        stall = (idle_mode == IDLE_RECV && $urandom_range(99) < 51) ||
                (idle_mode == IDLE_BOTH && $urandom_range(99) < 27);
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !stall;
        end
    end

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random bits above a register's width; the block must drop them
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = (32'd1 << w) - 32'd1;
        return (v & keep) | ($urandom() & ~keep);
    endfunction

    task automatic drain_all();
        while (pending_q.size() != 0 || holding || vtx_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_layout_item glyph_load(input int code, input int ax, input int ay,
                                                input int bw, input int bh, input int bl,
                                                input int bt, input int tx);
        t_layout_item it;
        it.cmd = CMD_LOAD;
        it.req = '{atlas_x: 16'(tx), bearing_top: 16'(bt), bearing_left: 16'(bl),
                   box_h: 12'(bh), box_w: 12'(bw), adv_y: 16'(ay), adv_x: 16'(ax),
                   start: 1'($urandom()), code: CODE_W'(code)};
        return it;
    endfunction

    function automatic t_layout_item glyph_draw(input int code, input bit start);
        t_layout_item it;
        it.cmd = CMD_DRAW;
        it.req = IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
        it.req.code = CODE_W'(code);
        it.req.start = start;
        return it;
    endfunction

    // Warm-up loads, then a mix of loads and draws biased to loaded codes
    task automatic fill_random(input int n_items, input bit wild);
        int           loaded[$];
        int           sel;
        t_layout_item it;
        for (int k = 0; k < n_items; k++) begin
            it.req = IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
            if (k < WARMUP_LOADS || $urandom_range(99) < 25) begin
                it.cmd = CMD_LOAD;
                if ($urandom_range(99) < 8) begin
                    it.req.code = CODE_W'($urandom_range(FIRST_CODE - 1));
                end else begin
                    it.req.code = CODE_W'($urandom_range(END_CODE - 1, FIRST_CODE));
                end
                // mostly modest metrics so the pen walks instead of pinning
                if (!wild && $urandom_range(99) < 80) begin
                    it.req.adv_x        = 16'(int'($urandom_range(48)) - 4);
                    it.req.adv_y        = 16'(int'($urandom_range(4)) - 2);
                    it.req.box_w        = 12'($urandom_range(40));
                    it.req.box_h        = 12'($urandom_range(40));
                    it.req.bearing_left = 16'(int'($urandom_range(8)) - 4);
                    it.req.bearing_top  = 16'($urandom_range(40));
                end
                if ($urandom_range(99) < 8) begin
                    it.req.box_w = '0;
                end
                if ($urandom_range(99) < 8) begin
                    it.req.box_h = '0;
                end
                if (code_in_table(it.req.code)) begin
                    loaded.push_back(int'(it.req.code));
                end
            end else begin
                it.cmd = CMD_DRAW;
                sel = $urandom_range(99);
                if (sel < 8) begin
                    it.req.code = CODE_W'(NEWLINE_CODE);
                end else if (sel < 14) begin
                    it.req.code = CODE_W'($urandom_range(FIRST_CODE - 1));
                end else if (sel < 80 && loaded.size() != 0) begin
                    it.req.code = CODE_W'(loaded[$urandom_range(loaded.size() - 1)]);
                end else begin
                    it.req.code = CODE_W'($urandom_range(END_CODE - 1, FIRST_CODE));
                end
                it.req.start = ($urandom_range(99) < 12);
            end
            pending_q.push_back(it);
        end
    endtask

    task automatic run_phase(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ps, input logic [31:0] aw,
                             input logic [31:0] ah, input t_idle_mode mode,
                             input int n_items, input bit long_hold, input bit wild);
        cfg_write(REG_ORIGIN_X, ox);
        cfg_write(REG_ORIGIN_Y, oy);
        cfg_write(REG_SCALE_X, with_junk(sx, SCALE_W));
        cfg_write(REG_SCALE_Y, with_junk(sy, SCALE_W));
        cfg_write(REG_POINT_SIZE, with_junk(ps, POINT_W));
        cfg_write(REG_ATLAS_W, with_junk(aw, ATLAS_W));
        cfg_write(REG_ATLAS_H, with_junk(ah, ATLAS_W));
        cfg_write(REG_UNUSED, $urandom());
        idle_mode = mode;
        hold_req  = long_hold;
        phase_cnt++;
        fill_random(n_items, wild);
        drain_all();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under reset register values
        pending_q.push_back(glyph_draw(65, 1'b0));    // entry never loaded reads as zero
        pending_q.push_back(glyph_load(65, 10, 0, 8, 12, 1, 12, 5));
        pending_q.push_back(glyph_draw(65, 1'b1));
        pending_q.push_back(glyph_draw(65, 1'b0));
        pending_q.push_back(glyph_draw(NEWLINE_CODE, 1'b0));
        pending_q.push_back(glyph_draw(65, 1'b0));
        pending_q.push_back(glyph_draw(NEWLINE_CODE, 1'b1));
        pending_q.push_back(glyph_draw(0, 1'b1));     // unprintable, start still applies
        pending_q.push_back(glyph_draw(9, 1'b0));
        pending_q.push_back(glyph_load(FIRST_CODE - 1, 5, 5, 5, 5, 5, 5, 5));
        pending_q.push_back(glyph_draw(FIRST_CODE - 1, 1'b0));
        pending_q.push_back(glyph_load(0, -1, -1, 4095, 4095, -1, -1, 65535));
        pending_q.push_back(glyph_load(END_CODE - 1, 32767, -32768, 4095, 4095,
                                       -32768, 32767, 65535));
        pending_q.push_back(glyph_draw(END_CODE - 1, 1'b0));
        pending_q.push_back(glyph_draw(END_CODE - 1, 1'b0));
        pending_q.push_back(glyph_load(FIRST_CODE, 4, 0, 0, 5, 0, 0, 0));     // zero width
        pending_q.push_back(glyph_draw(FIRST_CODE, 1'b0));
        pending_q.push_back(glyph_load(FIRST_CODE + 1, 4, 0, 5, 0, 0, 0, 0)); // zero height
        pending_q.push_back(glyph_draw(FIRST_CODE + 1, 1'b0));
        pending_q.push_back(glyph_load(126, -32768, 32767, 1, 1, 32767, -32768, 0));
        pending_q.push_back(glyph_draw(126, 1'b1));
        pending_q.push_back(glyph_load(65, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(glyph_draw(65, 1'b0));
        pending_q.push_back(glyph_draw(END_CODE - 1, 1'b1));
        phase_cnt++;
        drain_all();

        // Randomized phases across register settings and idle patterns
        run_phase(32'h0, 32'h0, 32'h0001_0000, 32'h0004_0000, 32'd1, 32'd65535, 32'd65535,
                  IDLE_NONE, 90, 1'b0, 1'b0);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'd1023,
                  32'd1, 32'd1, IDLE_SEND, 80, 1'b0, 1'b1);
        run_phase($urandom(), $urandom(), $urandom_range(32'h0100_0000),
                  $urandom_range(32'h0100_0000), $urandom_range(1023, 1), 32'd0, 32'd0,
                  IDLE_RECV, 90, 1'b1, 1'b0);
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd4096, 32'd0, 32'd300, 32'd77,
                  IDLE_BOTH, 30, 1'b0, 1'b0);
        run_phase({$urandom_range(3) == 0 ? 8'h00 : 8'hFF, 24'($urandom())}, $urandom(),
                  $urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
                  $urandom_range(1023, 1), $urandom_range(4096, 1), $urandom_range(4096, 1),
                  IDLE_BOTH, 90, 1'b0, 1'b0);
        run_phase(32'hF000_0000, 32'h0800_0000, 32'h0100_0000, 32'h0000_4000,
                  $urandom_range(64, 1), $urandom_range(65535, 1), $urandom_range(65535, 1),
                  IDLE_NONE, 60, 1'b0, 1'b1);

        $display("Covered %0d loads and %0d draws over %0d register settings,",
                 load_cnt, draw_cnt, phase_cnt);
        $display("%0d vertices checked with sender gaps, receiver stalls and a long hold-off.",
                 vert_cnt);
        if (err_cnt == 0 && vtx_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
